### sv/vth_pkg.sv
// shared constants, codes and structs of the viewport table hit test
package vth_pkg;

    localparam int COORD_BITS        = 13;
    localparam int MAX_VIEWPORTS_DEF = 16;
    localparam int OP_BITS           = 3;
    localparam int INDEX_BITS        = 4;
    localparam int COUNT_BITS        = 5;

    typedef logic [COORD_BITS-1:0] t_coord;

    typedef enum logic [OP_BITS-1:0] {
        OP_CREATE        = 3'd0,
        OP_ACTIVATE      = 3'd1,
        OP_RESIZE        = 3'd2,
        OP_CLIENT_RESIZE = 3'd3,
        OP_MAXIMIZE      = 3'd4,
        OP_SELECT        = 3'd5,
        OP_HIT_TEST      = 3'd6,
        OP_QUERY         = 3'd7
    } t_op;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic scan;
        logic capture_query;
        logic finish_scan;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        t_op  op;
        logic scan_done;
        logic out_free;
    } t_status;

    typedef struct packed {
        logic                  hit_found;
        logic [INDEX_BITS-1:0] hit_index;
        t_coord                rect_left;
        t_coord                rect_bottom;
        t_coord                rect_width;
        t_coord                rect_height;
        logic                  is_active;
        logic                  is_selected;
        logic                  index_error;
    } t_result;

endpackage

### sv/vth_ifs.sv
// valid/ready channel interfaces for input words and result words
interface vth_item_if;
    logic                              valid;
    logic                              ready;
    logic [vth_pkg::OP_BITS-1:0]       op;
    logic [vth_pkg::INDEX_BITS-1:0]    entry_index;
    logic [vth_pkg::COUNT_BITS-1:0]    entry_count;
    logic [vth_pkg::COORD_BITS-1:0]    pos_x;
    logic [vth_pkg::COORD_BITS-1:0]    pos_y;
    logic [vth_pkg::COORD_BITS-1:0]    size_w;
    logic [vth_pkg::COORD_BITS-1:0]    size_h;

    modport source (
        output valid, op, entry_index, entry_count, pos_x, pos_y, size_w, size_h,
        input  ready
    );
    modport sink (
        input  valid, op, entry_index, entry_count, pos_x, pos_y, size_w, size_h,
        output ready
    );
endinterface

interface vth_result_if;
    logic                              valid;
    logic                              ready;
    logic                              hit_found;
    logic [vth_pkg::INDEX_BITS-1:0]    hit_index;
    logic [vth_pkg::COORD_BITS-1:0]    rect_left;
    logic [vth_pkg::COORD_BITS-1:0]    rect_bottom;
    logic [vth_pkg::COORD_BITS-1:0]    rect_width;
    logic [vth_pkg::COORD_BITS-1:0]    rect_height;
    logic                              is_active;
    logic                              is_selected;
    logic                              index_error;

    modport source (
        output valid, hit_found, hit_index, rect_left, rect_bottom, rect_width,
               rect_height, is_active, is_selected, index_error,
        input  ready
    );
    modport sink (
        input  valid, hit_found, hit_index, rect_left, rect_bottom, rect_width,
               rect_height, is_active, is_selected, index_error,
        output ready
    );
endinterface

### sv/vth_controller.sv
// sequencer: accept, execute, table scan or query read, result hand-off
module vth_controller (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  vth_pkg::t_status i_status,
    output vth_pkg::t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_QUERY,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_ready;
    logic   n_in_ready;

    always_comb begin
        n_state    = r_state;
        n_in_ready = r_in_ready;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && r_in_ready) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                    n_in_ready = 1'b0;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_status.op == vth_pkg::OP_SELECT ||
                    i_status.op == vth_pkg::OP_HIT_TEST) begin
                    n_state = S_SCAN;
                end else if (i_status.op == vth_pkg::OP_QUERY) begin
                    n_state = S_QUERY;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_QUERY: begin
                o_cmd.capture_query = 1'b1;
                n_state             = S_FINISH;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_done) begin
                    o_cmd.finish_scan = 1'b1;
                    n_state           = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                    n_in_ready = 1'b1;
                end
            end
            default: begin
                n_state    = S_IDLE;
                n_in_ready = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_in_ready <= n_in_ready;
        end
    end

    assign o_in_ready = r_in_ready;

endmodule

### sv/vth_datapath.sv
// table storage, flags, point test and result registers
module vth_datapath #(
    parameter int MAX_VIEWPORTS = vth_pkg::MAX_VIEWPORTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  vth_pkg::t_cmd                     i_cmd,
    output vth_pkg::t_status                  o_status,
    input  logic [vth_pkg::OP_BITS-1:0]       i_op,
    input  logic [vth_pkg::INDEX_BITS-1:0]    i_entry_index,
    input  logic [vth_pkg::COUNT_BITS-1:0]    i_entry_count,
    input  vth_pkg::t_coord                   i_pos_x,
    input  vth_pkg::t_coord                   i_pos_y,
    input  vth_pkg::t_coord                   i_size_w,
    input  vth_pkg::t_coord                   i_size_h,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output vth_pkg::t_result                  o_result
);

    localparam int IW = (MAX_VIEWPORTS > 1) ? $clog2(MAX_VIEWPORTS) : 1;
    localparam int CW = $clog2(MAX_VIEWPORTS + 1);
    localparam int CB = vth_pkg::COORD_BITS;
    localparam int XB = vth_pkg::INDEX_BITS;

    // latched word
    vth_pkg::t_op                r_op;
    logic [XB-1:0]               r_idx;
    logic [vth_pkg::COUNT_BITS-1:0] r_cnt;
    vth_pkg::t_coord             r_px;
    vth_pkg::t_coord             r_py;
    vth_pkg::t_coord             r_sw;
    vth_pkg::t_coord             r_sh;

    // table state
    logic [CW-1:0]               r_count;
    vth_pkg::t_coord             r_client_w;
    vth_pkg::t_coord             r_client_h;
    logic                        r_max_vld;
    logic [IW-1:0]               r_max_entry;
    logic [MAX_VIEWPORTS-1:0]    r_active;
    logic [MAX_VIEWPORTS-1:0]    r_selected;
    logic [MAX_VIEWPORTS-1:0]    r_geo_vld;

    vth_pkg::t_coord             r_mem_left   [MAX_VIEWPORTS];
    vth_pkg::t_coord             r_mem_bottom [MAX_VIEWPORTS];
    vth_pkg::t_coord             r_mem_width  [MAX_VIEWPORTS];
    vth_pkg::t_coord             r_mem_height [MAX_VIEWPORTS];

    // read port and scan
    logic [IW-1:0]               r_scan_idx;
    logic                        r_rd_live;
    logic [IW-1:0]               r_rd_idx;
    vth_pkg::t_coord             r_rd_left;
    vth_pkg::t_coord             r_rd_bottom;
    vth_pkg::t_coord             r_rd_width;
    vth_pkg::t_coord             r_rd_height;
    logic                        r_rd_geo_vld;
    logic                        r_rd_active;
    logic                        r_rd_selected;
    logic [CB:0]                 r_y_flip;

    vth_pkg::t_result            r_pend;
    vth_pkg::t_result            r_out;
    logic                        r_out_vld;

    logic [IW+XB-1:0]            w_idx_wide;
    logic [IW-1:0]               w_idx;
    logic                        w_idx_ok;
    logic                        w_cnt_over;
    logic [CW-1:0]               w_cnt_sat;
    logic                        w_max_ok;
    logic [IW-1:0]               w_rd_addr;
    logic [IW-1:0]               w_wr_addr;
    logic                        w_wr_wh;
    logic                        w_wr_lb;
    vth_pkg::t_coord             w_wr_left;
    vth_pkg::t_coord             w_wr_bottom;
    vth_pkg::t_coord             w_wr_width;
    vth_pkg::t_coord             w_wr_height;
    vth_pkg::t_coord             w_g_left;
    vth_pkg::t_coord             w_g_bottom;
    vth_pkg::t_coord             w_g_width;
    vth_pkg::t_coord             w_g_height;
    logic                        w_y_neg;
    logic                        w_hit;
    logic                        w_last;
    logic [IW+XB-1:0]            w_rd_idx_wide;
    logic [MAX_VIEWPORTS-1:0]    w_idx_onehot;
    logic [MAX_VIEWPORTS-1:0]    w_hit_onehot;
    vth_pkg::t_result            w_exec_res;
    vth_pkg::t_result            w_query_res;
    vth_pkg::t_result            w_scan_res;

    assign w_idx_wide   = {{IW{1'b0}}, r_idx};
    assign w_idx        = w_idx_wide[IW-1:0];
    assign w_idx_ok     = 32'(r_idx) < 32'(r_count);
    assign w_cnt_over   = 32'(r_cnt) > 32'(MAX_VIEWPORTS);
    assign w_cnt_sat    = w_cnt_over ? CW'(MAX_VIEWPORTS) : CW'(r_cnt);
    assign w_max_ok     = r_max_vld && (32'(r_max_entry) < 32'(r_count));
    assign w_idx_onehot = MAX_VIEWPORTS'(1) << w_idx;
    assign w_hit_onehot = MAX_VIEWPORTS'(1) << r_rd_idx;

    assign w_rd_addr = i_cmd.scan ? r_scan_idx : w_idx;

    // table writes: resize, maximize, and client resize on the maximized entry
    assign w_wr_addr = (r_op == vth_pkg::OP_CLIENT_RESIZE) ? r_max_entry : w_idx;
    always_comb begin
        w_wr_wh = 1'b0;
        case (r_op)
            vth_pkg::OP_RESIZE:        w_wr_wh = i_cmd.exec && w_idx_ok;
            vth_pkg::OP_MAXIMIZE:      w_wr_wh = i_cmd.exec && w_idx_ok;
            vth_pkg::OP_CLIENT_RESIZE: w_wr_wh = i_cmd.exec && w_max_ok;
            default:                   w_wr_wh = 1'b0;
        endcase
    end
    // a cleared entry gets its zero origin written with its new size
    assign w_wr_lb = w_wr_wh &&
                     ((r_op != vth_pkg::OP_CLIENT_RESIZE) || !r_geo_vld[w_wr_addr]);
    assign w_wr_left   = (r_op == vth_pkg::OP_RESIZE) ? r_px : '0;
    assign w_wr_bottom = (r_op == vth_pkg::OP_RESIZE) ? r_py : '0;
    assign w_wr_width  = (r_op == vth_pkg::OP_MAXIMIZE) ? r_client_w : r_sw;
    assign w_wr_height = (r_op == vth_pkg::OP_MAXIMIZE) ? r_client_h : r_sh;

    always_ff @(posedge i_clk) begin
        if (w_wr_lb) begin
            r_mem_left[w_wr_addr]   <= w_wr_left;
            r_mem_bottom[w_wr_addr] <= w_wr_bottom;
        end
        if (w_wr_wh) begin
            r_mem_width[w_wr_addr]  <= w_wr_width;
            r_mem_height[w_wr_addr] <= w_wr_height;
        end
        r_rd_left     <= r_mem_left[w_rd_addr];
        r_rd_bottom   <= r_mem_bottom[w_rd_addr];
        r_rd_width    <= r_mem_width[w_rd_addr];
        r_rd_height   <= r_mem_height[w_rd_addr];
        r_rd_geo_vld  <= r_geo_vld[w_rd_addr];
        r_rd_active   <= r_active[w_rd_addr];
        r_rd_selected <= r_selected[w_rd_addr];
        r_rd_idx      <= w_rd_addr;
    end

    // geometry of a cleared entry reads as zero
    assign w_g_left   = r_rd_geo_vld ? r_rd_left   : '0;
    assign w_g_bottom = r_rd_geo_vld ? r_rd_bottom : '0;
    assign w_g_width  = r_rd_geo_vld ? r_rd_width  : '0;
    assign w_g_height = r_rd_geo_vld ? r_rd_height : '0;

    // strict containment, y already flipped and possibly negative
    assign w_y_neg = r_y_flip[CB];
    assign w_hit = r_rd_live && r_rd_active &&
                   (r_px > w_g_left) &&
                   ({1'b0, r_px} < ({1'b0, w_g_left} + {1'b0, w_g_width})) &&
                   !w_y_neg && (r_y_flip[CB-1:0] > w_g_bottom) &&
                   ({1'b0, r_y_flip[CB-1:0]} < ({1'b0, w_g_bottom} + {1'b0, w_g_height}));
    assign w_last = r_rd_live && ((32'(r_rd_idx) + 32'd1) == 32'(r_count));
    assign w_rd_idx_wide = {{XB{1'b0}}, r_rd_idx};

    always_comb begin
        w_exec_res = '0;
        case (r_op)
            vth_pkg::OP_CREATE:        w_exec_res.index_error = w_cnt_over;
            vth_pkg::OP_ACTIVATE:      w_exec_res.index_error = !w_idx_ok;
            vth_pkg::OP_RESIZE:        w_exec_res.index_error = !w_idx_ok;
            vth_pkg::OP_MAXIMIZE:      w_exec_res.index_error = !w_idx_ok;
            default:                   w_exec_res.index_error = 1'b0;
        endcase
    end

    always_comb begin
        w_query_res = '0;
        if (w_idx_ok) begin
            w_query_res.rect_left   = w_g_left;
            w_query_res.rect_bottom = w_g_bottom;
            w_query_res.rect_width  = w_g_width;
            w_query_res.rect_height = w_g_height;
            w_query_res.is_active   = r_rd_active;
            w_query_res.is_selected = r_rd_selected;
        end else begin
            w_query_res.index_error = 1'b1;
        end
    end

    always_comb begin
        w_scan_res           = '0;
        w_scan_res.hit_found = w_hit;
        w_scan_res.hit_index = w_hit ? w_rd_idx_wide[XB-1:0] : '0;
    end

    // latched word and scratch registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= vth_pkg::t_op'(i_op);
            r_idx <= i_entry_index;
            r_cnt <= i_entry_count;
            r_px  <= i_pos_x;
            r_py  <= i_pos_y;
            r_sw  <= i_size_w;
            r_sh  <= i_size_h;
        end
        if (i_cmd.exec) begin
            r_y_flip   <= {1'b0, r_client_h} - {1'b0, r_py};
            r_scan_idx <= '0;
            r_pend     <= w_exec_res;
        end else if (i_cmd.scan) begin
            r_scan_idx <= r_scan_idx + IW'(1);
        end
        if (i_cmd.capture_query) begin
            r_pend <= w_query_res;
        end
        if (i_cmd.finish_scan) begin
            r_pend <= w_scan_res;
        end
        if (i_cmd.emit) begin
            r_out <= r_pend;
        end
    end

    // control and table state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_client_w <= '0;
            r_client_h <= '0;
            r_max_vld  <= 1'b0;
            r_max_entry <= '0;
            r_active   <= '0;
            r_selected <= '0;
            r_geo_vld  <= '0;
            r_rd_live  <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_rd_live <= i_cmd.scan && (32'(r_scan_idx) < 32'(r_count));
            if (i_cmd.exec) begin
                case (r_op)
                    vth_pkg::OP_CREATE: begin
                        r_count    <= w_cnt_sat;
                        r_geo_vld  <= '0;
                        r_selected <= '0;
                        for (int i = 0; i < MAX_VIEWPORTS; i++) begin
                            r_active[i] <= 32'(i) < 32'(w_cnt_sat);
                        end
                    end
                    vth_pkg::OP_ACTIVATE: begin
                        if (w_idx_ok) begin
                            r_active[w_idx] <= 1'b1;
                        end
                    end
                    vth_pkg::OP_CLIENT_RESIZE: begin
                        r_client_w <= r_sw;
                        r_client_h <= r_sh;
                    end
                    vth_pkg::OP_MAXIMIZE: begin
                        if (w_idx_ok) begin
                            r_active    <= w_idx_onehot;
                            r_max_vld   <= 1'b1;
                            r_max_entry <= w_idx;
                        end
                    end
                    default: begin
                    end
                endcase
                if (w_wr_wh) begin
                    r_geo_vld[w_wr_addr] <= 1'b1;
                end
            end
            if (i_cmd.finish_scan && (r_op == vth_pkg::OP_SELECT)) begin
                r_selected <= w_hit ? w_hit_onehot : '0;
            end
            if (i_cmd.emit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_status.op        = r_op;
    assign o_status.scan_done = w_hit || w_last || (r_count == '0);
    assign o_status.out_free  = !r_out_vld || i_out_ready;

    assign o_out_valid = r_out_vld;
    assign o_result    = r_out;

endmodule

### sv/viewport_table_hit_test.sv
// top level of the viewport table with point hit test
// usage:
//   i_item carries one command word (create, activate, resize, client resize,
//   maximize, select, hit test, query); it is taken when valid and ready are
//   both high. o_result returns exactly one result word per command word.
//   the block works on one command at a time: ready drops after a word is
//   taken and rises again once its result sits in the output register.
// sequencing:
//   table updates and create go from accept through execute to the result
//   register; a query adds one registered read of the geometry memories.
//   select and hit test walk the table one entry per cycle through the
//   single read port, stopping at the first hit or after the last of the
//   entries in use.
// reset:
//   synchronous active-low reset empties the table, zeroes the client size
//   and maximized entry, and drops output valid; no clearing pass is needed.
// stall:
//   the output register holds a word until taken; a new command is already
//   accepted while it waits, and its own result waits until the slot frees.
module viewport_table_hit_test #(
    parameter int MAX_VIEWPORTS = vth_pkg::MAX_VIEWPORTS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    vth_item_if.sink      i_item,
    vth_result_if.source  o_result
);

    vth_pkg::t_cmd    w_cmd;      // sequencer commands
    vth_pkg::t_status w_status;   // datapath status back to the sequencer
    vth_pkg::t_result w_result;   // registered result word
    logic             w_in_ready;
    logic             w_out_valid;

    // sequencer: accept, execute, walk or read, hand off
    vth_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // table memories, flags, containment test and output register
    vth_datapath #(
        .MAX_VIEWPORTS (MAX_VIEWPORTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_op          (i_item.op),
        .i_entry_index (i_item.entry_index),
        .i_entry_count (i_item.entry_count),
        .i_pos_x       (i_item.pos_x),
        .i_pos_y       (i_item.pos_y),
        .i_size_w      (i_item.size_w),
        .i_size_h      (i_item.size_h),
        .i_out_ready   (o_result.ready),
        .o_out_valid   (w_out_valid),
        .o_result      (w_result)
    );

    assign i_item.ready = w_in_ready;

    // result channel
    assign o_result.valid       = w_out_valid;
    assign o_result.hit_found   = w_result.hit_found;
    assign o_result.hit_index   = w_result.hit_index;
    assign o_result.rect_left   = w_result.rect_left;
    assign o_result.rect_bottom = w_result.rect_bottom;
    assign o_result.rect_width  = w_result.rect_width;
    assign o_result.rect_height = w_result.rect_height;
    assign o_result.is_active   = w_result.is_active;
    assign o_result.is_selected = w_result.is_selected;
    assign o_result.index_error = w_result.index_error;

endmodule

### sv/vth_checker.sv
// port-level checks of the viewport table, bound to the top level
module vth_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic                           i_hit_found,
    input logic [vth_pkg::INDEX_BITS-1:0] i_hit_index,
    input vth_pkg::t_coord                i_rect_left,
    input vth_pkg::t_coord                i_rect_bottom,
    input vth_pkg::t_coord                i_rect_width,
    input vth_pkg::t_coord                i_rect_height,
    input logic                           i_is_active,
    input logic                           i_is_selected,
    input logic                           i_index_error
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid &&
            $stable(i_hit_found) && $stable(i_hit_index) && $stable(i_rect_left) &&
            $stable(i_rect_bottom) && $stable(i_rect_width) &&
            $stable(i_rect_height) && $stable(i_is_active) &&
            $stable(i_is_selected) && $stable(i_index_error))
        else $error("result word changed while stalled");

    // one command in flight at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("ready stayed high after a word was taken");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // no hit means index zero
    a_no_hit_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_hit_found |-> i_hit_index == '0)
        else $error("hit index set without a hit");

    // an index error carries no geometry or flags
    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_index_error |->
            i_rect_left == '0 && i_rect_bottom == '0 && i_rect_width == '0 &&
            i_rect_height == '0 && !i_is_active && !i_is_selected && !i_hit_found)
        else $error("index error word carries data");

endmodule

bind viewport_table_hit_test vth_checker u_vth_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_item.valid),
    .i_in_ready    (i_item.ready),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_hit_found   (o_result.hit_found),
    .i_hit_index   (o_result.hit_index),
    .i_rect_left   (o_result.rect_left),
    .i_rect_bottom (o_result.rect_bottom),
    .i_rect_width  (o_result.rect_width),
    .i_rect_height (o_result.rect_height),
    .i_is_active   (o_result.is_active),
    .i_is_selected (o_result.is_selected),
    .i_index_error (o_result.index_error)
);

### test/tb_viewport_table_hit_test.sv
// self-checking testbench of the viewport table: directed corners, then random scenes
module tb_viewport_table_hit_test;

    localparam int MAX_ENTRIES  = vth_pkg::MAX_VIEWPORTS_DEF;
    localparam int COORD_MAX    = (1 << vth_pkg::COORD_BITS) - 1;
    // cycles without any handshake before the run is called hung; set above the
    // slowest legal word plus a long result stall
    localparam int STALL_LIMIT  = 1000;
    // settle time after the last result, sized from the longest scan
    localparam int DRAIN_CYCLES = 2 * (MAX_ENTRIES + 3);
    localparam int RANDOM_WORDS = 525;

    // one command word as the sender sees it
    typedef struct {
        vth_pkg::t_op                   op;
        logic [vth_pkg::INDEX_BITS-1:0] idx;
        logic [vth_pkg::COUNT_BITS-1:0] cnt;
        vth_pkg::t_coord                px;
        vth_pkg::t_coord                py;
        vth_pkg::t_coord                sw;
        vth_pkg::t_coord                sh;
    } t_cmd_word;

    // how the result side throttles ready
    typedef enum int {
        STALL_NONE,
        STALL_COIN,
        STALL_PERIODIC,
        STALL_RARE
    } t_stall_mode;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    vth_item_if   item_if ();
    vth_result_if res_if ();

    viewport_table_hit_test u_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_if),
        .o_result (res_if)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // mirror of the viewport table, updated once per accepted word
    // ------------------------------------------------------------------
    vth_pkg::t_coord table_left   [MAX_ENTRIES];
    vth_pkg::t_coord table_bottom [MAX_ENTRIES];
    vth_pkg::t_coord table_width  [MAX_ENTRIES];
    vth_pkg::t_coord table_height [MAX_ENTRIES];
    bit              table_active [MAX_ENTRIES];
    bit              table_selected [MAX_ENTRIES];
    int              entries_in_use;
    vth_pkg::t_coord client_w;
    vth_pkg::t_coord client_h;
    bit              max_valid;
    int              max_entry;

    // results still owed by the block, oldest first
    vth_pkg::t_result expected_results[$];

    int failures      = 0;
    int words_sent    = 0;
    int results_seen  = 0;
    int hits_found    = 0;
    int index_errors  = 0;
    int burst_left    = 0;
    int op_count [8];

    function automatic void clear_model();
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            table_left[i]     = '0;
            table_bottom[i]   = '0;
            table_width[i]    = '0;
            table_height[i]   = '0;
            table_active[i]   = 1'b0;
            table_selected[i] = 1'b0;
        end
        entries_in_use = 0;
        client_w       = '0;
        client_h       = '0;
        max_valid      = 1'b0;
        max_entry      = 0;
        for (int i = 0; i < 8; i++) op_count[i] = 0;
    endfunction

    // first active entry in use that strictly contains the point, -1 if none;
    // y is flipped against the client height and may go negative
    function automatic int locate_hit(vth_pkg::t_coord px, vth_pkg::t_coord py);
        int x;
        int y;
        x = int'(px);
        y = int'(client_h) - int'(py);
        for (int i = 0; i < entries_in_use; i++) begin
            if (x > int'(table_left[i]) &&
                x < int'(table_left[i]) + int'(table_width[i]) &&
                y > int'(table_bottom[i]) &&
                y < int'(table_bottom[i]) + int'(table_height[i]) &&
                table_active[i])
                return i;
        end
        return -1;
    endfunction

    // applies one word to the mirror and returns the result it must produce
    function automatic vth_pkg::t_result apply_command(t_cmd_word c);
        vth_pkg::t_result r;
        bit               in_range;
        int               n;
        int               hit;
        int               e;
        r        = '0;
        e        = int'(c.idx);
        in_range = e < entries_in_use;
        op_count[c.op]++;
        case (c.op)
            vth_pkg::OP_CREATE: begin
                n = int'(c.cnt);
                // counts above the table size saturate and are flagged
                if (n > MAX_ENTRIES) begin
                    n             = MAX_ENTRIES;
                    r.index_error = 1'b1;
                end
                entries_in_use = n;
                for (int i = 0; i < MAX_ENTRIES; i++) begin
                    table_left[i]     = '0;
                    table_bottom[i]   = '0;
                    table_width[i]    = '0;
                    table_height[i]   = '0;
                    table_active[i]   = i < n;
                    table_selected[i] = 1'b0;
                end
            end
            vth_pkg::OP_ACTIVATE: begin
                if (in_range) table_active[e] = 1'b1;
                else r.index_error = 1'b1;
            end
            vth_pkg::OP_RESIZE: begin
                if (in_range) begin
                    table_left[e]   = c.px;
                    table_bottom[e] = c.py;
                    table_width[e]  = c.sw;
                    table_height[e] = c.sh;
                end else begin
                    r.index_error = 1'b1;
                end
            end
            vth_pkg::OP_CLIENT_RESIZE: begin
                client_w = c.sw;
                client_h = c.sh;
                // the maximized entry follows the client area while in use
                if (max_valid && max_entry < entries_in_use) begin
                    table_width[max_entry]  = c.sw;
                    table_height[max_entry] = c.sh;
                end
            end
            vth_pkg::OP_MAXIMIZE: begin
                if (in_range) begin
                    for (int i = 0; i < MAX_ENTRIES; i++) table_active[i] = 1'b0;
                    table_active[e] = 1'b1;
                    table_left[e]   = '0;
                    table_bottom[e] = '0;
                    table_width[e]  = client_w;
                    table_height[e] = client_h;
                    max_valid       = 1'b1;
                    max_entry       = e;
                end else begin
                    r.index_error = 1'b1;
                end
            end
            vth_pkg::OP_SELECT, vth_pkg::OP_HIT_TEST: begin
                hit = locate_hit(c.px, c.py);
                // select leaves exactly the hit entry selected, or none
                if (c.op == vth_pkg::OP_SELECT)
                    for (int i = 0; i < MAX_ENTRIES; i++) table_selected[i] = (hit == i);
                if (hit >= 0) begin
                    r.hit_found = 1'b1;
                    r.hit_index = hit[vth_pkg::INDEX_BITS-1:0];
                end
            end
            vth_pkg::OP_QUERY: begin
                if (in_range) begin
                    r.rect_left   = table_left[e];
                    r.rect_bottom = table_bottom[e];
                    r.rect_width  = table_width[e];
                    r.rect_height = table_height[e];
                    r.is_active   = table_active[e];
                    r.is_selected = table_selected[e];
                end else begin
                    r.index_error = 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (r.hit_found) hits_found++;
        if (r.index_error) index_errors++;
        return r;
    endfunction

    function automatic t_cmd_word make_word(vth_pkg::t_op op, int idx, int cnt,
                                            int px, int py, int sw, int sh);
        t_cmd_word c;
        c.op  = op;
        c.idx = idx[vth_pkg::INDEX_BITS-1:0];
        c.cnt = cnt[vth_pkg::COUNT_BITS-1:0];
        c.px  = px[vth_pkg::COORD_BITS-1:0];
        c.py  = py[vth_pkg::COORD_BITS-1:0];
        c.sw  = sw[vth_pkg::COORD_BITS-1:0];
        c.sh  = sh[vth_pkg::COORD_BITS-1:0];
        return c;
    endfunction

    function automatic int rand_coord();
        return $urandom_range(0, COORD_MAX);
    endfunction

    // mostly an entry in use, sometimes anything the field allows
    function automatic int pick_index();
        if (entries_in_use > 0 && $urandom_range(0, 4) != 0)
            return $urandom_range(0, entries_in_use - 1);
        return $urandom_range(0, MAX_ENTRIES - 1);
    endfunction

    // window point strictly inside entry e, if one can be expressed
    function automatic bit point_inside(int e, output vth_pkg::t_coord px,
                                        output vth_pkg::t_coord py);
        int x;
        int y;
        px = '0;
        py = '0;
        if (e >= entries_in_use || table_width[e] < 2 || table_height[e] < 2)
            return 1'b0;
        x = int'(table_left[e]) + $urandom_range(1, int'(table_width[e]) - 1);
        y = int'(table_bottom[e]) + $urandom_range(1, int'(table_height[e]) - 1);
        if (x > COORD_MAX || y > int'(client_h))
            return 1'b0;
        px = x[vth_pkg::COORD_BITS-1:0];
        py = vth_pkg::COORD_BITS'(int'(client_h) - y);
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // sender: drives one word, holds it until taken, then maybe pauses;
    // valid stays high across a burst so back-to-back words need no gap
    // ------------------------------------------------------------------
    task automatic send_cmd(t_cmd_word c);
        int gap;
        item_if.valid       <= 1'b1;
        item_if.op          <= c.op;
        item_if.entry_index <= c.idx;
        item_if.entry_count <= c.cnt;
        item_if.pos_x       <= c.px;
        item_if.pos_y       <= c.py;
        item_if.size_w      <= c.sw;
        item_if.size_h      <= c.sh;
        do @(posedge clk); while (item_if.ready !== 1'b1);
        expected_results.push_back(apply_command(c));
        words_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                item_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // directed tests
    // ------------------------------------------------------------------

    // nothing in use yet: every index is out of range, nothing can be hit
    task automatic test_empty_table();
        send_cmd(make_word(vth_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0));
        send_cmd(make_word(vth_pkg::OP_ACTIVATE, 15, 0, 0, 0, 0, 0));
        send_cmd(make_word(vth_pkg::OP_HIT_TEST, 0, 0, 0, 0, 0, 0));
        send_cmd(make_word(vth_pkg::OP_CLIENT_RESIZE, 0, 0, 0, 0, 100, 100));
    endtask

    // create with an oversized count saturates, create with zero empties
    task automatic test_create_limits();
        send_cmd(make_word(vth_pkg::OP_CREATE, 0, 31, 0, 0, 0, 0));
        send_cmd(make_word(vth_pkg::OP_QUERY, 15, 0, 0, 0, 0, 0));
        send_cmd(make_word(vth_pkg::OP_CREATE, 0, 0, 0, 0, 0, 0));
        send_cmd(make_word(vth_pkg::OP_CREATE, 0, 3, 0, 0, 0, 0));
    endtask

    // strict containment on the left and bottom edges and a point above the client area
    task automatic test_rect_edges();
        send_cmd(make_word(vth_pkg::OP_RESIZE, 0, 0, 10, 10, 20, 20));
        send_cmd(make_word(vth_pkg::OP_RESIZE, 1, 0, COORD_MAX, COORD_MAX,
                           COORD_MAX, COORD_MAX));
        send_cmd(make_word(vth_pkg::OP_RESIZE, 3, 0, 5, 5, 5, 5));
        send_cmd(make_word(vth_pkg::OP_HIT_TEST, 0, 0, 10, 85, 0, 0));   // on left edge
        send_cmd(make_word(vth_pkg::OP_HIT_TEST, 0, 0, 11, 85, 0, 0));   // just inside
        send_cmd(make_word(vth_pkg::OP_HIT_TEST, 0, 0, 29, 90, 0, 0));   // on bottom edge
        send_cmd(make_word(vth_pkg::OP_HIT_TEST, 0, 0, 29, 71, 0, 0));   // top right corner
        send_cmd(make_word(vth_pkg::OP_HIT_TEST, 0, 0, 20, COORD_MAX, 0, 0)); // y negative
        send_cmd(make_word(vth_pkg::OP_QUERY, 1, 0, 0, 0, 0, 0));
    endtask

    // maximize follows client resizes; select marks one entry, a miss clears all
    task automatic test_maximize_select();
        send_cmd(make_word(vth_pkg::OP_SELECT, 0, 0, 15, 85, 0, 0));
        send_cmd(make_word(vth_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0));
        send_cmd(make_word(vth_pkg::OP_MAXIMIZE, 2, 0, 0, 0, 0, 0));
        send_cmd(make_word(vth_pkg::OP_CLIENT_RESIZE, 0, 0, 0, 0, 50, 60));
        send_cmd(make_word(vth_pkg::OP_QUERY, 2, 0, 0, 0, 0, 0));
        send_cmd(make_word(vth_pkg::OP_SELECT, 0, 0, 25, 30, 0, 0));
        send_cmd(make_word(vth_pkg::OP_SELECT, 0, 0, 55, 30, 0, 0));
        send_cmd(make_word(vth_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0));
        send_cmd(make_word(vth_pkg::OP_ACTIVATE, 0, 0, 0, 0, 0, 0));
    endtask

    // ------------------------------------------------------------------
    // random scenes: build a table that fits the client area, then poke it
    // with hit tests aimed inside entries, queries, edits and some noise
    // ------------------------------------------------------------------
    task automatic test_random_scenes(int words);
        int              target;
        int              cnt;
        int              kind;
        int              l;
        int              b;
        vth_pkg::t_coord px;
        vth_pkg::t_coord py;
        target = words_sent + words;
        while (words_sent < target) begin
            cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                              : $urandom_range(1, MAX_ENTRIES);
            send_cmd(make_word(vth_pkg::OP_CREATE, $urandom_range(0, 15), cnt,
                               rand_coord(), rand_coord(), rand_coord(), rand_coord()));
            if ($urandom_range(0, 3) != 0) begin
                if ($urandom_range(0, 3) != 0)
                    send_cmd(make_word(vth_pkg::OP_CLIENT_RESIZE, $urandom_range(0, 15),
                                       $urandom_range(0, 31), rand_coord(), rand_coord(),
                                       $urandom_range(32, COORD_MAX),
                                       $urandom_range(32, COORD_MAX)));
                else
                    send_cmd(make_word(vth_pkg::OP_CLIENT_RESIZE, 0, 0, 0, 0,
                                       rand_coord(), rand_coord()));
            end
            // lay out most entries inside the client area
            for (int e = 0; e < entries_in_use; e++) begin
                if ($urandom_range(0, 4) != 0) begin
                    l = $urandom_range(0, int'(client_w));
                    b = $urandom_range(0, int'(client_h));
                    send_cmd(make_word(vth_pkg::OP_RESIZE, e, $urandom_range(0, 31), l, b,
                                       $urandom_range(0, int'(client_w) - l),
                                       $urandom_range(0, int'(client_h) - b)));
                end
            end
            repeat ($urandom_range(8, 24)) begin
                kind = $urandom_range(0, 99);
                if (kind < 45) begin
                    if (!($urandom_range(0, 99) < 65 &&
                          point_inside($urandom_range(0, MAX_ENTRIES - 1), px, py))) begin
                        px = rand_coord();
                        py = rand_coord();
                    end
                    send_cmd(make_word($urandom_range(0, 1) ? vth_pkg::OP_SELECT
                                                            : vth_pkg::OP_HIT_TEST,
                                       $urandom_range(0, 15), $urandom_range(0, 31),
                                       px, py, rand_coord(), rand_coord()));
                end else if (kind < 60) begin
                    send_cmd(make_word(vth_pkg::OP_QUERY, pick_index(),
                                       $urandom_range(0, 31), rand_coord(), rand_coord(),
                                       rand_coord(), rand_coord()));
                end else if (kind < 70) begin
                    // full-range rectangles exercise the wide edge sums
                    send_cmd(make_word(vth_pkg::OP_RESIZE, pick_index(),
                                       $urandom_range(0, 31), rand_coord(), rand_coord(),
                                       rand_coord(), rand_coord()));
                end else if (kind < 76) begin
                    send_cmd(make_word(vth_pkg::OP_ACTIVATE, pick_index(),
                                       $urandom_range(0, 31), rand_coord(), rand_coord(),
                                       rand_coord(), rand_coord()));
                end else if (kind < 82) begin
                    send_cmd(make_word(vth_pkg::OP_MAXIMIZE, pick_index(),
                                       $urandom_range(0, 31), rand_coord(), rand_coord(),
                                       rand_coord(), rand_coord()));
                end else if (kind < 88) begin
                    send_cmd(make_word(vth_pkg::OP_CLIENT_RESIZE, $urandom_range(0, 15),
                                       $urandom_range(0, 31), rand_coord(), rand_coord(),
                                       $urandom_range(16, COORD_MAX),
                                       $urandom_range(16, COORD_MAX)));
                end else begin
                    // noise: any op with any field values
                    send_cmd(make_word(vth_pkg::t_op'($urandom_range(0, 7)),
                                       $urandom_range(0, 15), $urandom_range(0, 31),
                                       rand_coord(), rand_coord(), rand_coord(),
                                       rand_coord()));
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // result side: ready follows a changing stall pattern
    // ------------------------------------------------------------------
    initial begin : result_stall_pattern
        t_stall_mode mode;
        int          mode_left;
        int          phase;
        int          on_len;
        int          off_len;
        res_if.ready = 1'b0;
        mode         = STALL_NONE;
        mode_left    = 0;
        phase        = 0;
        on_len       = 1;
        off_len      = 1;
        forever begin
            @(posedge clk);
            if (mode_left == 0) begin
                mode      = t_stall_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(50, 300);
                on_len    = $urandom_range(1, 8);
                off_len   = $urandom_range(1, 12);
                phase     = 0;
            end
            mode_left--;
            case (mode)
                STALL_NONE:     res_if.ready <= 1'b1;
                STALL_COIN:     res_if.ready <= ($urandom_range(0, 1) == 1);
                STALL_PERIODIC: begin
                    res_if.ready <= (phase < on_len);
                    phase = (phase + 1) % (on_len + off_len);
                end
                default:        res_if.ready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // result checking against the oldest expectation
    // ------------------------------------------------------------------
    task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    initial begin : result_checker
        vth_pkg::t_result want;
        forever begin
            @(posedge clk);
            if (rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $error("result word with no command outstanding");
                    failures++;
                end else begin
                    want = expected_results.pop_front();
                    compare_field("hit_found",   want.hit_found,   res_if.hit_found);
                    compare_field("hit_index",   want.hit_index,   res_if.hit_index);
                    compare_field("rect_left",   want.rect_left,   res_if.rect_left);
                    compare_field("rect_bottom", want.rect_bottom, res_if.rect_bottom);
                    compare_field("rect_width",  want.rect_width,  res_if.rect_width);
                    compare_field("rect_height", want.rect_height, res_if.rect_height);
                    compare_field("is_active",   want.is_active,   res_if.is_active);
                    compare_field("is_selected", want.is_selected, res_if.is_selected);
                    compare_field("index_error", want.index_error, res_if.index_error);
                end
            end
        end
    end

    // ends the run when no word moves on either side for too long
    initial begin : progress_watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((item_if.valid === 1'b1 && item_if.ready === 1'b1) ||
                (res_if.valid === 1'b1 && res_if.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $error("no progress for %0d cycles, %0d results outstanding",
               STALL_LIMIT, expected_results.size());
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        item_if.valid       = 1'b0;
        item_if.op          = '0;
        item_if.entry_index = '0;
        item_if.entry_count = '0;
        item_if.pos_x       = '0;
        item_if.pos_y       = '0;
        item_if.size_w      = '0;
        item_if.size_h      = '0;
        clear_model();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_create_limits();
        test_rect_edges();
        test_maximize_select();
        test_random_scenes(RANDOM_WORDS);

        item_if.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        // catch any stray word the block might still emit
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb: %0d words checked (%0d results), %0d found a hit, %0d index errors",
                 words_sent, results_seen, hits_found, index_errors);
        $display("tb: ops create %0d activate %0d resize %0d client %0d maximize %0d %s %0d %s %0d %s %0d",
                 op_count[vth_pkg::OP_CREATE], op_count[vth_pkg::OP_ACTIVATE],
                 op_count[vth_pkg::OP_RESIZE], op_count[vth_pkg::OP_CLIENT_RESIZE],
                 op_count[vth_pkg::OP_MAXIMIZE], "select", op_count[vth_pkg::OP_SELECT],
                 "hit test", op_count[vth_pkg::OP_HIT_TEST],
                 "query", op_count[vth_pkg::OP_QUERY]);
        if (failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
